>>> hw/rtl/plts_pkg.sv
// Package: shared types, constants and payload structs for the tint shader.
`default_nettype none
package plts_pkg;
  localparam int MaxLightsDefault = 16;
  localparam int CoordBits = 20;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] RegActive = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegRange  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegMin    = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegRed    = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegGreen  = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegBlue   = 3'd5;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpShade = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [3:0]                slot;
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic signed [CoordBits-1:0] pos_z;
    logic [15:0]               reach;
    logic [8:0]                strength;
    logic signed [CoordBits-1:0] viewer_x;
    logic signed [CoordBits-1:0] viewer_y;
    logic signed [CoordBits-1:0] viewer_z;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] level;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start_term;  // begin a falloff term for the current source
    logic player;      // source is the viewer rather than a table slot
    logic first;       // initialize the accumulator from this term
    logic accumulate;  // add the finished term
    logic finish;      // form the output colour
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic term_done;
  } dp_sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/point_light_tint_shader.sv
// Top level: configuration registers, handshakes, controller and datapath.
// A load transaction writes a table slot and gives no result. A shade
// transaction runs the player light and then each of the N active lights
// (N up to 16) through one shared term unit: squared distance, a
// two-bit-per-cycle square root of 25 steps, a load step plus a 26-step
// one-bit-per-cycle divider, then the term. The input stalls from the
// accepted shade until the color is formed, which waits while the
// receiver still holds the previous color.
// One shade is processed at a time; its result sits in an output register
// while the next transaction is accepted.
`default_nettype none
module point_light_tint_shader #(
  parameter int MAX_LIGHTS = plts_pkg::MaxLightsDefault
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  plts_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output plts_pkg::out_item_t  out_data,
  input  wire                  cfg_we,
  input  wire [plts_pkg::CfgIdxBits-1:0]  cfg_index,
  input  wire [plts_pkg::CfgDataBits-1:0] cfg_data
);
  localparam int IW = $clog2(MAX_LIGHTS + 1);

  logic [4:0]  active_lights;
  logic [15:0] player_range;
  logic [8:0]  min_level, base_red, base_green, base_blue;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_lights <= 5'd0;
      player_range  <= 16'd1000;
      min_level     <= 9'd51;
      base_red      <= 9'd256;
      base_green    <= 9'd218;
      base_blue     <= 9'd179;
    end else if (cfg_we) begin
      case (cfg_index)
        plts_pkg::RegActive: active_lights <= cfg_data[4:0];
        plts_pkg::RegRange:  player_range  <= cfg_data[15:0];
        plts_pkg::RegMin:    min_level     <= cfg_data[8:0];
        plts_pkg::RegRed:    base_red      <= cfg_data[8:0];
        plts_pkg::RegGreen:  base_green    <= cfg_data[8:0];
        plts_pkg::RegBlue:   base_blue     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic busy, in_take, start, out_free;
  plts_pkg::dp_cmd_t cmd;
  plts_pkg::dp_sts_t sts;
  logic [IW-1:0] light_idx;

  assign in_stall = busy;
  assign in_take  = in_valid && !in_stall;
  assign start    = in_take && (in_data.op == plts_pkg::OpShade);
  assign out_free = !out_valid || !out_stall;

  // Output valid register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  plts_ctrl #(.MAX_LIGHTS(MAX_LIGHTS)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .active_lights(active_lights),
    .sts(sts), .out_free(out_free), .cmd(cmd), .light_idx(light_idx), .busy(busy)
  );

  plts_datapath #(.MAX_LIGHTS(MAX_LIGHTS)) u_dp (
    .clk(clk), .rst(rst),
    .load_we(in_take && (in_data.op == plts_pkg::OpLoad)),
    .item(in_data), .capture(start), .cmd(cmd), .light_idx(light_idx),
    .player_range(player_range), .min_level(min_level),
    .base_red(base_red), .base_green(base_green), .base_blue(base_blue),
    .sts(sts), .result(out_data)
  );

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("shade not started");
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> busy) else $error("finish outside shade");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/plts_ctrl.sv
// Controller: sequences the player light and each active table light.
`default_nettype none
module plts_ctrl #(
  parameter int MAX_LIGHTS = plts_pkg::MaxLightsDefault
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  wire [4:0]               active_lights,
  input  plts_pkg::dp_sts_t       sts,
  input  wire                     out_free,
  output plts_pkg::dp_cmd_t       cmd,
  output logic [$clog2(MAX_LIGHTS+1)-1:0] light_idx,
  output logic                    busy
);
  localparam int IW = $clog2(MAX_LIGHTS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PLAY = 5'b00010,
    S_LITE = 5'b00100,
    S_NEXT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [IW-1:0] count, count_next, idx_next;
  logic          issued, issued_next;

  // Number of contributing lights, saturated at the table depth
  logic [IW-1:0] n_lights;
  always_comb begin
    if (32'(active_lights) > MAX_LIGHTS) n_lights = IW'(MAX_LIGHTS);
    else n_lights = IW'(active_lights);
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = light_idx;
    issued_next = issued;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next  = S_PLAY;
          issued_next = 1'b0;
          count_next  = n_lights;
          idx_next    = '0;
        end
      end
      S_PLAY: begin
        cmd.player = 1'b1;
        if (!issued) begin
          cmd.start_term = 1'b1;
          issued_next    = 1'b1;
        end else if (sts.term_done) begin
          cmd.first   = 1'b1;
          issued_next = 1'b0;
          state_next  = (count == '0) ? S_DONE : S_LITE;
        end
      end
      S_LITE: begin
        if (!issued) begin
          cmd.start_term = 1'b1;
          issued_next    = 1'b1;
        end else if (sts.term_done) begin
          cmd.accumulate = 1'b1;
          issued_next    = 1'b0;
          idx_next       = light_idx + 1'b1;
          state_next     = S_NEXT;
        end
      end
      // Wait for the table read of the next slot to land
      S_NEXT: begin
        state_next = (light_idx == count) ? S_DONE : S_LITE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      light_idx <= '0;
      issued    <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      light_idx <= idx_next;
      issued    <= issued_next;
    end
  end

  assign busy = (state != S_IDLE);

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    light_idx <= IW'(MAX_LIGHTS)) else $error("light index past table");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> out_free) else $error("finish while output full");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start_term, cmd.first, cmd.accumulate, cmd.finish}))
    else $error("conflicting commands");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/plts_datapath.sv
// Datapath: light table, serial square root, serial divider, accumulator.
`default_nettype none
module plts_datapath #(
  parameter int MAX_LIGHTS = plts_pkg::MaxLightsDefault
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      load_we,
  input  plts_pkg::in_item_t       item,
  input  wire                      capture,
  input  plts_pkg::dp_cmd_t        cmd,
  input  wire [$clog2(MAX_LIGHTS+1)-1:0] light_idx,
  input  wire [15:0]               player_range,
  input  wire [8:0]                min_level,
  input  wire [8:0]                base_red,
  input  wire [8:0]                base_green,
  input  wire [8:0]                base_blue,
  output plts_pkg::dp_sts_t        sts,
  output plts_pkg::out_item_t      result
);
  localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int CW = plts_pkg::CoordBits;

  // Light table memory
  logic signed [CW-1:0] mem_x [MAX_LIGHTS];
  logic signed [CW-1:0] mem_y [MAX_LIGHTS];
  logic signed [CW-1:0] mem_z [MAX_LIGHTS];
  logic [15:0]          mem_r [MAX_LIGHTS];
  logic [8:0]           mem_s [MAX_LIGHTS];
  logic signed [CW-1:0] rd_x, rd_y, rd_z;
  logic [15:0]          rd_r;
  logic [8:0]           rd_s;
  logic [AW-1:0]        rd_addr;

  assign rd_addr = AW'(light_idx);
  always_ff @(posedge clk) begin
    if (load_we && 32'(item.slot) < MAX_LIGHTS) begin
      mem_x[AW'(item.slot)] <= CW'(item.pos_x);
      mem_y[AW'(item.slot)] <= CW'(item.pos_y);
      mem_z[AW'(item.slot)] <= CW'(item.pos_z);
      mem_r[AW'(item.slot)] <= item.reach;
      mem_s[AW'(item.slot)] <= item.strength;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
    rd_z <= mem_z[rd_addr];
    rd_r <= mem_r[rd_addr];
    rd_s <= mem_s[rd_addr];
  end

  // Shaded point and viewer captured with the shade transaction
  logic signed [CW-1:0] px, py, pz, vx, vy, vz;
  always_ff @(posedge clk) begin
    if (capture) begin
      px <= CW'(item.pos_x); py <= CW'(item.pos_y); pz <= CW'(item.pos_z);
      vx <= CW'(item.viewer_x); vy <= CW'(item.viewer_y); vz <= CW'(item.viewer_z);
    end
  end

  // Term sequencer: diff -> square sum over the three axes -> sqrt -> divide
  typedef enum logic [5:0] {
    T_IDLE = 6'b000001,
    T_SQ   = 6'b000010,
    T_ROOT = 6'b000100,
    T_DIV  = 6'b001000,
    T_TERM = 6'b010000,
    T_DONE = 6'b100000
  } tstate_t;

  tstate_t tst;
  logic signed [CW:0] dx, dy, dz;
  logic [15:0] range;
  logic [8:0]  str;
  logic        far;
  logic [1:0]  axis;
  logic [33:0] sumsq;
  logic [50:0] rad;      // radicand shift register
  logic [25:0] root;
  logic [25:0] rem;
  logic [4:0]  step;
  logic [25:0] quot;
  logic [16:0] drem;
  logic [8:0]  term;
  logic [15:0] mag;

  always_comb begin
    case (axis)
      2'd0:    mag = dx[CW] ? 16'(-dx) : 16'(dx);
      2'd1:    mag = dy[CW] ? 16'(-dy) : 16'(dy);
      default: mag = dz[CW] ? 16'(-dz) : 16'(dz);
    endcase
  end

  function automatic logic is_far(input logic signed [CW:0] d);
    logic signed [CW:0] a;
    a = d[CW] ? -d : d;
    return (longint'(a) >= 65536);
  endfunction

  // Root: 2 radicand bits per step, 25 steps for the 50-bit sumsq<<16
  logic [27:0] trial;
  assign trial = {rem, rad[50:49]} - {root, 2'b01};

  logic [16:0] dtrial;
  assign dtrial = {drem[15:0], quot[25]} - {1'b0, range};

  always_ff @(posedge clk) begin
    if (rst) begin
      tst <= T_IDLE;
    end else begin
      case (tst)
        T_IDLE: begin
          if (cmd.start_term) begin
            if (cmd.player) begin
              dx <= (CW+1)'(vx) - (CW+1)'(px);
              dy <= (CW+1)'(vy) - (CW+1)'(py);
              dz <= (CW+1)'(vz) - (CW+1)'(pz);
              range <= player_range; str <= 9'd256;
            end else begin
              dx <= (CW+1)'(rd_x) - (CW+1)'(px);
              dy <= (CW+1)'(rd_y) - (CW+1)'(py);
              dz <= (CW+1)'(rd_z) - (CW+1)'(pz);
              range <= rd_r; str <= rd_s;
            end
            axis <= 2'd0; sumsq <= '0;
            tst <= T_SQ;
          end
        end
        T_SQ: begin
          sumsq <= sumsq + 34'(32'(mag) * 32'(mag));
          if (axis == 2'd2) begin
            far <= is_far(dx) || is_far(dy) || is_far(dz) || (range == 16'd0);
            tst <= T_ROOT; step <= '0;
            rad <= {sumsq + 34'(32'(mag) * 32'(mag)), 16'd0, 1'b0};
            root <= '0; rem <= '0;
          end
          axis <= axis + 2'd1;
        end
        T_ROOT: begin
          if (!trial[27]) begin
            rem <= trial[25:0]; root <= {root[24:0], 1'b1};
          end else begin
            rem <= {rem[23:0], rad[50:49]}; root <= {root[24:0], 1'b0};
          end
          rad <= {rad[48:0], 2'b00};
          if (step == 5'd24) begin
            tst <= T_DIV; step <= 5'd31; drem <= '0;
          end else begin
            step <= step + 5'd1;
          end
        end
        T_DIV: begin
          // load the root, then restoring division by range, one bit a cycle
          if (step == 5'd31) begin
            quot <= root; step <= '0;
          end else begin
            if (!dtrial[16]) begin
              drem <= dtrial; quot <= {quot[24:0], 1'b1};
            end else begin
              drem <= {drem[15:0], quot[25]}; quot <= {quot[24:0], 1'b0};
            end
            step <= step + 5'd1;
            if (step == 5'd25) tst <= T_TERM;
          end
        end
        T_TERM: begin
          if (far || quot >= 26'd256) term <= '0;
          else term <= 9'd256 - 9'(quot);
          tst <= T_DONE;
        end
        T_DONE: tst <= T_IDLE;
        default: tst <= T_IDLE;
      endcase
    end
  end
  assign sts.term_done = (tst == T_DONE);

  // Accumulator and clamp
  logic [13:0] acc;
  logic [17:0] contrib;
  logic [8:0]  lvl;
  assign contrib = 18'(term) * 18'(str);

  function automatic logic [8:0] clampv(input logic [13:0] v, input logic [8:0] m);
    logic [13:0] t;
    t = (v < 14'(m)) ? 14'(m) : v;
    return (t > 14'd256) ? 9'd256 : 9'(t);
  endfunction

  function automatic logic [7:0] chan(input logic [8:0] b, input logic [8:0] l);
    logic [25:0] p;
    p = (26'(b) * 26'(l) * 26'd255) >> 16;
    return (p > 26'd255) ? 8'd255 : 8'(p);
  endfunction

  assign lvl = clampv(acc, min_level);

  always_ff @(posedge clk) begin
    if (cmd.first) acc <= 14'(clampv(14'(term), min_level));
    else if (cmd.accumulate) acc <= acc + 14'(contrib[17:8]);
    if (cmd.finish) begin
      result.red   <= chan(base_red, lvl);
      result.green <= chan(base_green, lvl);
      result.blue  <= chan(base_blue, lvl);
      result.level <= lvl;
    end
  end

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    tst == T_DONE |=> tst == T_IDLE) else $error("term done not single cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start_term |-> tst == T_IDLE) else $error("term started while busy");
  a_term_range: assert property (@(posedge clk) disable iff (rst)
    tst == T_DONE |-> term <= 9'd256) else $error("term out of range");
`endif
endmodule
`default_nettype wire

>>> tb/sv/plts_checker.sv
// Checker for the point light tint shader: watches the channels, predicts and compares.
`timescale 1ns / 1ps
module plts_checker (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  in_stall,
  input  plts_pkg::in_item_t   in_data,
  input  wire                  out_valid,
  input  wire                  out_stall,
  input  plts_pkg::out_item_t  out_data,
  input  wire                  cfg_we,
  input  wire [plts_pkg::CfgIdxBits-1:0]  cfg_index,
  input  wire [plts_pkg::CfgDataBits-1:0] cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   shades_seen,
  output int                   loads_seen
);
  localparam int NumSlots = plts_pkg::MaxLightsDefault;
  localparam int CB = plts_pkg::CoordBits;

  // Shadow copy of the configuration registers
  logic [4:0]  num_active;
  logic [15:0] viewer_reach;
  logic [8:0]  floor_level;
  logic [8:0]  tint_r, tint_g, tint_b;

  // Shadow copy of the light table
  logic signed [CB-1:0] lamp_x [NumSlots];
  logic signed [CB-1:0] lamp_y [NumSlots];
  logic signed [CB-1:0] lamp_z [NumSlots];
  logic [15:0]          lamp_reach [NumSlots];
  logic [8:0]           lamp_strength [NumSlots];

  plts_pkg::out_item_t colors_due[$];

  assign pending = colors_due.size();

  // Integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs_delta(longint a, longint b);
    longint d;
    d = a - b;
    return (d < 0) ? unsigned'(-d) : unsigned'(d);
  endfunction

  // Q8 linear falloff between two points
  function automatic int unsigned falloff_q8(longint ax, longint ay, longint az,
                                             longint bx, longint by, longint bz,
                                             logic [15:0] range);
    longint unsigned dx, dy, dz, q;
    dx = abs_delta(ax, bx);
    dy = abs_delta(ay, by);
    dz = abs_delta(az, bz);
    if (range == 0) return 0;
    if (dx >= 65536 || dy >= 65536 || dz >= 65536) return 0;
    q = int_sqrt((dx * dx + dy * dy + dz * dz) << 16) / 64'(range);
    return (q >= 256) ? 0 : 32'(256 - q);
  endfunction

  function automatic int unsigned clamp_bright(int unsigned v);
    if (v < 32'(floor_level)) v = 32'(floor_level);
    if (v > 256) v = 256;
    return v;
  endfunction

  function automatic logic [7:0] tint_channel(logic [8:0] base, int unsigned lvl);
    longint unsigned c;
    c = (64'(base) * 64'(lvl) * 64'd255) >> 16;
    return (c > 255) ? 8'd255 : c[7:0];
  endfunction

  function automatic plts_pkg::out_item_t shade_color(plts_pkg::in_item_t it);
    plts_pkg::out_item_t o;
    int unsigned lvl, n, t;
    longint      px, py, pz;
    px = longint'(it.pos_x);
    py = longint'(it.pos_y);
    pz = longint'(it.pos_z);
    lvl = clamp_bright(falloff_q8(longint'(it.viewer_x), longint'(it.viewer_y),
                                  longint'(it.viewer_z), px, py, pz, viewer_reach));
    n = (32'(num_active) > NumSlots) ? NumSlots : 32'(num_active);
    for (int i = 0; i < n; i++) begin
      t = falloff_q8(longint'(lamp_x[i]), longint'(lamp_y[i]), longint'(lamp_z[i]),
                     px, py, pz, lamp_reach[i]);
      lvl += (t * 32'(lamp_strength[i])) >> 8;
    end
    lvl = clamp_bright(lvl);
    o.red   = tint_channel(tint_r, lvl);
    o.green = tint_channel(tint_g, lvl);
    o.blue  = tint_channel(tint_b, lvl);
    o.level = lvl[8:0];
    return o;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH %s", $time, what);
    errors++;
  endtask

  // Register writes
  always @(posedge clk) begin
    if (rst) begin
      num_active   <= 5'd0;
      viewer_reach <= 16'd1000;
      floor_level  <= 9'd51;
      tint_r       <= 9'd256;
      tint_g       <= 9'd218;
      tint_b       <= 9'd179;
    end else if (cfg_we) begin
      case (cfg_index)
        plts_pkg::RegActive: num_active   <= cfg_data[4:0];
        plts_pkg::RegRange:  viewer_reach <= cfg_data;
        plts_pkg::RegMin:    floor_level  <= cfg_data[8:0];
        plts_pkg::RegRed:    tint_r       <= cfg_data[8:0];
        plts_pkg::RegGreen:  tint_g       <= cfg_data[8:0];
        plts_pkg::RegBlue:   tint_b       <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Input transactions: table loads and color predictions
  always @(posedge clk) begin
    if (rst) begin
      shades_seen <= 0;
      loads_seen  <= 0;
    end else if (in_valid && !in_stall) begin
      if (in_data.op == plts_pkg::OpLoad) begin
        lamp_x[in_data.slot]        <= in_data.pos_x;
        lamp_y[in_data.slot]        <= in_data.pos_y;
        lamp_z[in_data.slot]        <= in_data.pos_z;
        lamp_reach[in_data.slot]    <= in_data.reach;
        lamp_strength[in_data.slot] <= in_data.strength;
        loads_seen <= loads_seen + 1;
      end else begin
        colors_due = {colors_due, shade_color(in_data)};
        shades_seen <= shades_seen + 1;
      end
    end
  end

  // Output transactions against the oldest prediction
  initial errors = 0;
  always @(posedge clk) begin
    plts_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (colors_due.size() == 0) begin
        report_mismatch("unexpected color transaction");
      end else begin
        want = colors_due.pop_front();
        if (out_data.red !== want.red)
          report_mismatch($sformatf("red: got %0d, expected %0d", out_data.red, want.red));
        if (out_data.green !== want.green)
          report_mismatch($sformatf("green: got %0d, expected %0d",
                                    out_data.green, want.green));
        if (out_data.blue !== want.blue)
          report_mismatch($sformatf("blue: got %0d, expected %0d",
                                    out_data.blue, want.blue));
        if (out_data.level !== want.level)
          report_mismatch($sformatf("level: got %0d, expected %0d",
                                    out_data.level, want.level));
      end
    end
  end
endmodule

>>> tb/sv/tb_point_light_tint_shader.sv
// Testbench top for the point light tint shader: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_point_light_tint_shader;
  localparam int SettleCycles = 1300;
  localparam int IdleLimit    = 30000;
  localparam int HoldCycles   = 3000;
  localparam int CB   = plts_pkg::CoordBits;
  localparam int IdxW = plts_pkg::CfgIdxBits;
  localparam int DatW = plts_pkg::CfgDataBits;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  plts_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  plts_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [DatW-1:0] cfg_data = '0;

  int errors, pending, shades_seen, loads_seen;
  bit hold_req = 1'b0;
  int idle_cycles = 0;
  int fails;
  logic signed [CB-1:0] cx, cy, cz;  // scene center of the current phase

  always #10 clk = ~clk;

  point_light_tint_shader u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  plts_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending),
    .shades_seen(shades_seen), .loads_seen(loads_seen)
  );

  // Gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Coordinate near the phase center, or anywhere now and then
  function automatic logic signed [CB-1:0] coord(logic signed [CB-1:0] c, int spread);
    if ($urandom_range(0, 9) == 0) return CB'($urandom());
    return c + CB'($urandom_range(0, 2 * spread)) - CB'(spread);
  endfunction

  function automatic plts_pkg::in_item_t light_load(int slot);
    plts_pkg::in_item_t it;
    it = '0;
    it.op       = plts_pkg::OpLoad;
    it.slot     = 4'(slot);
    it.pos_x    = coord(cx, 3000);
    it.pos_y    = coord(cy, 3000);
    it.pos_z    = coord(cz, 3000);
    it.reach    = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                              : 16'($urandom_range(0, 6000));
    it.strength = ($urandom_range(0, 7) == 0) ? 9'($urandom())
                                              : 9'($urandom_range(0, 256));
    it.viewer_x = CB'($urandom());
    it.viewer_y = CB'($urandom());
    it.viewer_z = CB'($urandom());
    return it;
  endfunction

  function automatic plts_pkg::in_item_t shade_point();
    plts_pkg::in_item_t it;
    it = '0;
    it.op       = plts_pkg::OpShade;
    it.slot     = 4'($urandom());
    it.reach    = 16'($urandom());
    it.strength = 9'($urandom());
    it.pos_x    = coord(cx, 3000);
    it.pos_y    = coord(cy, 3000);
    it.pos_z    = coord(cz, 3000);
    it.viewer_x = coord(it.pos_x, 1500);
    it.viewer_y = coord(it.pos_y, 1500);
    it.viewer_z = coord(it.pos_z, 1500);
    return it;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send(plts_pkg::in_item_t it);
    int g;
    in_valid <= 1'b1;
    in_data  <= it;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Wait for all colors, let the block drain, then write every register
  task automatic set_regs(int act, int rng, int mn, int r, int g, int b);
    int vals[6];
    vals = '{act, rng, mn, r, g, b};
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= IdxW'(i);
      cfg_data  <= DatW'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic shade_at(int px, int py, int pz, int vx, int vy, int vz);
    plts_pkg::in_item_t it;
    it = '0;
    it.op = plts_pkg::OpShade;
    it.pos_x = CB'(px); it.pos_y = CB'(py); it.pos_z = CB'(pz);
    it.viewer_x = CB'(vx); it.viewer_y = CB'(vy); it.viewer_z = CB'(vz);
    send(it);
  endtask

  task automatic load_at(int s, int px, int py, int pz, int rch, int str);
    plts_pkg::in_item_t it;
    it = '0;
    it.op = plts_pkg::OpLoad;
    it.slot = 4'(s);
    it.pos_x = CB'(px); it.pos_y = CB'(py); it.pos_z = CB'(pz);
    it.reach = 16'(rch);
    it.strength = 9'(str);
    send(it);
  endtask

  // Receiver stalls, with one long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = gap_len();
        out_stall <= (n > 0);
        repeat ((n > 0) ? n : $urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int act, cnt;
    cx = '0; cy = '0; cz = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fill the whole table, the first slots with field extremes
    load_at(0, -524288, -524288, -524288, 65535, 256);
    load_at(1, 524287, 524287, 524287, 65535, 511);
    load_at(2, 0, 0, 0, 0, 256);
    load_at(3, 100, 0, 0, 1, 256);
    load_at(4, 0, 65535, 0, 65535, 256);
    load_at(5, 0, 0, 65536, 65535, 256);
    for (int s = 6; s < 16; s++) load_at(s, 200 * s, -50 * s, 30, 400 * s, 20 * s);
    // defaults, no table lights: player light only
    shade_at(0, 0, 0, 0, 0, 0);
    shade_at(0, 0, 0, 999, 0, 0);
    shade_at(-524288, 524287, 0, 524287, -524288, 0);

    // All lights, oversized count, widest range, strong tint
    set_regs(31, 65535, 0, 511, 0, 256);
    shade_at(0, 0, 0, 0, 0, 0);
    shade_at(0, 65535, 0, 0, 0, 0);
    shade_at(524287, 524287, 524287, 524287, 524287, 524287);
    // zero range, minimum above one
    set_regs(16, 0, 300, 256, 256, 256);
    shade_at(0, 0, 0, 0, 0, 0);
    set_regs(0, 1, 256, 0, 511, 1);
    shade_at(0, 0, 0, 0, 0, 0);

    // Random phases: mostly few lights, one at full table
    for (int ph = 0; ph < 12; ph++) begin
      cx = CB'($urandom()); cy = CB'($urandom()); cz = CB'($urandom());
      act = (ph == 5) ? 16 : $urandom_range(0, 4);
      set_regs(act,
               ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(1, 4000),
               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                                           : $urandom_range(0, 256),
               $urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 511));
      // place all sixteen table lights around this center
      for (int s = 0; s < 16; s++) send(light_load(s));
      if (ph == 2) hold_req = 1'b1;
      cnt = (ph == 5) ? 15 : 80;
      for (int i = 0; i < cnt; i++) begin
        if ($urandom_range(0, 3) == 0) send(light_load($urandom_range(0, 15)));
        else send(shade_point());
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    fails = errors + pending;
    $display("covered %0d shade and %0d load transactions", shades_seen, loads_seen);
    $display("over 15 register settings, incl. full table, zero range and strong tint");
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

>>> point_light_tint_shader.f
hw/rtl/plts_pkg.sv
hw/rtl/plts_ctrl.sv
hw/rtl/plts_datapath.sv
hw/rtl/point_light_tint_shader.sv
tb/sv/plts_checker.sv
tb/sv/tb_point_light_tint_shader.sv
